### rtl/core/abd_pkg.sv
// shared types and constants of the arcade bus decoder
`default_nettype none

package abd_pkg;

    typedef enum logic [2:0] {
        OP_MEM_RD  = 3'd0,
        OP_MEM_WR  = 3'd1,
        OP_IO_RD   = 3'd2,
        OP_IO_WR   = 3'd3,
        OP_VBLANK  = 3'd4,
        OP_FRAME   = 3'd5,
        OP_ROM_LD  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        RD_ROM  = 2'd0,
        RD_RAM  = 2'd1,
        RD_BYTE = 2'd2
    } t_rd_sel;

    localparam int unsigned ROM_DEPTH   = 16384;
    localparam int unsigned ROM_AW      = 14;
    localparam int unsigned WRAM_DEPTH  = 4096;
    localparam int unsigned SPR_DEPTH   = 16;
    // work ram first, sprite bytes right after it
    localparam int unsigned RAM_DEPTH   = WRAM_DEPTH + SPR_DEPTH;
    localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);

    localparam logic [14:0] ADDR_MASK    = 15'h7FFF;
    localparam logic [14:0] ADDR_WRAM    = 15'h4000;
    localparam logic [14:0] ADDR_IO      = 15'h5000;
    localparam logic [14:0] ADDR_IRQ_EN  = 15'h5000;
    localparam logic [14:0] ADDR_SND_EN  = 15'h5001;
    localparam logic [14:0] ADDR_FLIP    = 15'h5003;
    localparam logic [14:0] ADDR_PA_END  = 15'h503F;
    localparam logic [14:0] ADDR_PB_END  = 15'h507F;
    localparam logic [14:0] ADDR_DIP_END = 15'h50BF;
    localparam logic [14:0] ADDR_IO_END  = 15'h50FF;
    localparam logic [14:0] ADDR_SND     = 15'h5040;
    localparam logic [14:0] ADDR_SND_END = 15'h505F;
    localparam logic [14:0] ADDR_SPR     = 15'h5060;
    localparam logic [14:0] ADDR_SPR_END = 15'h506F;

    localparam logic [7:0] VECTOR_RESET = 8'hFA;
    localparam logic [7:0] DIP_RESET    = 8'hC9;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  player_port_a;
        logic [7:0]  player_port_b;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       sound_write_valid;
        logic [4:0] sound_register;
        logic [7:0] sound_value;
        logic       sound_enable_valid;
        logic       sound_enable_value;
        logic       irq_fire;
        logic [7:0] irq_vector_out;
        logic       flip_state;
    } t_result;

    typedef struct packed {
        logic       irq_enabled;
        logic       irq_waiting;
        logic       screen_flip;
        logic [7:0] vector_latch;
    } t_latches;

    typedef struct packed {
        logic              ram_we;
        logic [RAM_AW-1:0] ram_waddr;
        logic [RAM_AW-1:0] ram_raddr;
        logic              rom_we;
        logic [ROM_AW-1:0] rom_addr;
        t_rd_sel           rd_sel;
        logic [7:0]        rd_byte;
        logic              snd_valid;
        logic [4:0]        snd_reg;
        logic              sen_valid;
        logic              sen_value;
        logic              fire;
    } t_dec;

endpackage

`default_nettype wire

### rtl/core/abd_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module abd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/abd_decode.sv
// address decode and latch update for one bus item
`default_nettype none

module abd_decode
    import abd_pkg::*;
#(
    parameter bit FORCE_SOUND_ON = 1'b0
) (
    input  wire t_in_item   i_item,
    input  wire t_latches   i_cur,
    input  wire logic [7:0] i_dip,
    output t_dec            o_dec,
    output t_latches        o_next
);

    logic [14:0] a;
    logic [14:0] snd_off;
    logic [14:0] spr_off;

    assign a       = i_item.addr[14:0] & ADDR_MASK;
    assign snd_off = a - ADDR_SND;
    assign spr_off = a - ADDR_SPR;

    always_comb begin
        o_dec           = '0;
        o_dec.rd_sel    = RD_BYTE;
        o_dec.rd_byte   = OPEN_BUS;
        o_dec.rom_addr  = i_item.addr[ROM_AW-1:0];
        o_dec.ram_raddr = RAM_AW'(a[11:0]);
        o_dec.ram_waddr = RAM_AW'(a[11:0]);
        o_next          = i_cur;

        unique case (i_item.op)
            OP_MEM_RD: begin
                if (a < ADDR_WRAM) begin
                    o_dec.rd_sel = RD_ROM;
                end else if (a < ADDR_IO) begin
                    o_dec.rd_sel = RD_RAM;
                end else if (a <= ADDR_PA_END) begin
                    o_dec.rd_byte = i_item.player_port_a;
                end else if (a <= ADDR_PB_END) begin
                    o_dec.rd_byte = i_item.player_port_b;
                end else if (a <= ADDR_DIP_END) begin
                    o_dec.rd_byte = i_dip;
                end
            end
            OP_MEM_WR: begin
                if (a >= ADDR_WRAM && a < ADDR_IO) begin
                    o_dec.ram_we = 1'b1;
                end else if (a == ADDR_IRQ_EN) begin
                    o_next.irq_enabled = i_item.data[0];
                    if (!i_item.data[0]) begin
                        o_next.irq_waiting = 1'b0;
                    end
                end else if (a == ADDR_SND_EN) begin
                    o_dec.sen_valid = 1'b1;
                    o_dec.sen_value = FORCE_SOUND_ON | i_item.data[0];
                end else if (a == ADDR_FLIP) begin
                    o_next.screen_flip = i_item.data[0];
                end else if (a >= ADDR_SND && a <= ADDR_SND_END) begin
                    o_dec.snd_valid = 1'b1;
                    o_dec.snd_reg   = snd_off[4:0];
                end else if (a >= ADDR_SPR && a <= ADDR_SPR_END) begin
                    o_dec.ram_we    = 1'b1;
                    o_dec.ram_waddr = RAM_AW'(WRAM_DEPTH) + RAM_AW'(spr_off[3:0]);
                end
            end
            OP_IO_RD: begin
                o_dec.rd_byte = OPEN_BUS;
            end
            OP_IO_WR: begin
                if (i_item.addr[7:0] == 8'd0) begin
                    o_next.vector_latch = i_item.data;
                end
            end
            OP_VBLANK: begin
                if (i_cur.irq_enabled) begin
                    o_next.irq_waiting = 1'b1;
                end
            end
            OP_FRAME: begin
                if (i_cur.irq_enabled && i_cur.irq_waiting) begin
                    o_dec.fire         = 1'b1;
                    o_next.irq_waiting = 1'b0;
                end
            end
            OP_ROM_LD: begin
                o_dec.rom_we = 1'b1;
            end
            default: begin
                o_dec.rd_byte = OPEN_BUS;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/arcade_bus_decoder_with_irq_latch_unit.sv
// top level of the arcade bus decoder with interrupt latch
//
//   channel  signals                        handshake
//   item in  start, busy, i_item            taken when start and not busy
//   result   o_done, o_result               one cycle strobe, cannot stall
//   config   i_cfg_valid, o_cfg_ready,      written when valid and ready
//            i_cfg_data
//
// an item's result appears in the cycle after it is taken; one item
// per cycle is taken while busy is low
// after reset the work ram and sprite bytes are zeroed, one entry a cycle,
// all 4112 entries with busy high; the program rom keeps its contents
// the config port is always ready
`default_nettype none

module arcade_bus_decoder_with_irq_latch_unit
    import abd_pkg::*;
#(
    parameter bit FORCE_SOUND_ON = 1'b0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_done,
    output t_result       o_result,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic              accept;
    t_dec              dec;
    t_latches          r_lat;
    t_latches          n_lat;
    logic [7:0]        r_dip;
    logic              r_clr;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;
    logic [7:0]        rom_q;

    logic              r_done;
    t_rd_sel           r_rd_sel;
    logic [7:0]        r_rd_byte;
    logic              r_snd_valid;
    logic [4:0]        r_snd_reg;
    logic [7:0]        r_snd_val;
    logic              r_sen_valid;
    logic              r_sen_val;
    logic              r_fire;
    logic [7:0]        r_vec;
    logic              r_flip;

    assign busy        = r_clr;
    assign accept      = start && !r_clr;
    assign o_cfg_ready = 1'b1;

    abd_decode #(
        .FORCE_SOUND_ON(FORCE_SOUND_ON)
    ) u_decode (
        .i_item(i_item),
        .i_cur (r_lat),
        .i_dip (r_dip),
        .o_dec (dec),
        .o_next(n_lat)
    );

    assign ram_we    = r_clr || (accept && dec.ram_we);
    assign ram_waddr = r_clr ? r_clr_addr : dec.ram_waddr;
    assign ram_wdata = r_clr ? 8'd0 : i_item.data;

    abd_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_work_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(dec.ram_raddr),
        .o_rdata(ram_q)
    );

    abd_ram #(
        .WIDTH(8),
        .DEPTH(ROM_DEPTH)
    ) u_program_rom (
        .i_clk  (i_clk),
        .i_we   (accept && dec.rom_we),
        .i_waddr(dec.rom_addr),
        .i_wdata(i_item.data),
        .i_raddr(dec.rom_addr),
        .o_rdata(rom_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat.irq_enabled  <= 1'b0;
            r_lat.irq_waiting  <= 1'b0;
            r_lat.screen_flip  <= 1'b0;
            r_lat.vector_latch <= VECTOR_RESET;
            r_dip              <= DIP_RESET;
            r_clr              <= 1'b1;
            r_clr_addr         <= '0;
            r_done             <= 1'b0;
        end else begin
            if (accept) begin
                r_lat <= n_lat;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_dip <= i_cfg_data;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_done <= accept;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_sel    <= dec.rd_sel;
            r_rd_byte   <= dec.rd_byte;
            r_snd_valid <= dec.snd_valid;
            r_snd_reg   <= dec.snd_reg;
            r_snd_val   <= dec.snd_valid ? i_item.data : 8'd0;
            r_sen_valid <= dec.sen_valid;
            r_sen_val   <= dec.sen_value;
            r_fire      <= dec.fire;
            r_vec       <= dec.fire ? r_lat.vector_latch : 8'd0;
            r_flip      <= n_lat.screen_flip;
        end
    end

    always_comb begin
        unique case (r_rd_sel)
            RD_ROM:  o_result.read_data = rom_q;
            RD_RAM:  o_result.read_data = ram_q;
            default: o_result.read_data = r_rd_byte;
        endcase
        o_result.sound_write_valid  = r_snd_valid;
        o_result.sound_register     = r_snd_reg;
        o_result.sound_value        = r_snd_val;
        o_result.sound_enable_valid = r_sen_valid;
        o_result.sound_enable_value = r_sen_val;
        o_result.irq_fire           = r_fire;
        o_result.irq_vector_out     = r_vec;
        o_result.flip_state         = r_flip;
    end

    assign o_done = r_done;

endmodule

`default_nettype wire
